// ===== design/plbook_pkg.sv =====
// plbook_pkg: types and constants shared by the price level book modules
// no dependencies
`timescale 1ns / 1ps

package plbook_pkg;

    // item field widths
    localparam int LEVEL_W    = 12;
    localparam int QTY_W      = 32;
    localparam int CSUM_W     = 64;

    // stream packing
    localparam int IN_TDATA_W = 48;  // price_level, quantity, zero fill
    localparam int IN_TUSER_W = 3;   // req_type, book_side, clear_level
    localparam int OUT_TDATA_W = 64; // book_checksum

    localparam int TU_REQ   = 0;
    localparam int TU_SIDE  = 1;
    localparam int TU_CLR   = 2;
    localparam int TD_LEVEL_LO = 0;
    localparam int TD_QTY_LO   = 12;

    // request kinds and book sides
    localparam logic REQ_UPDATE   = 1'b0;
    localparam logic REQ_CHECKSUM = 1'b1;
    localparam logic SIDE_BID     = 1'b0;
    localparam logic SIDE_ASK     = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPD_WR,
        ST_SUM_RUN,
        ST_SUM_DRAIN,
        ST_SUM_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic take_item;   // latch update fields, read at the item's level
        logic scan_start;  // clear accumulator and level counter
        logic clear_step;  // write zero to both tables at the counter
        logic scan_step;   // read both tables at the counter
        logic upd_write;   // write the updated level back
        logic out_load;    // move the sum into the output register
    } cmd_t;

    typedef struct packed {
        logic cnt_last;
        logic pipe_busy;
        logic out_free;
    } sts_t;

endpackage

// ===== design/price_level_book_with_checksum.sv =====
// price_level_book_with_checksum: bid/ask level book with weighted checksum (plbook_ctrl, plbook_dp)
// update item: read-modify-write through the one read port of each table ram, no new item until written back
// checksum item: one level per cycle scan, then the pipeline drains and the sum loads into the free output register
// the next item can be taken in the cycle the result becomes valid; a waiting result does not block updates
// reset: both tables are swept to zero level by level after rst_n rises, s_axis_tready low
`timescale 1ns / 1ps

module price_level_book_with_checksum #(
    parameter int LEVELS = 4096
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // input items
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [11:0] price_level, [43:12] quantity, [47:44] zero
    input  logic [plbook_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // [0] req_type, [1] book_side, [2] clear_level
    input  logic [plbook_pkg::IN_TUSER_W-1:0]    s_axis_tuser,
    // result items
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [63:0] book_checksum
    output logic [plbook_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

    // unpacked input fields
    logic                                req_type;
    logic                                book_side;
    logic                                clear_level;
    logic [plbook_pkg::LEVEL_W-1:0]      price_level;
    logic signed [plbook_pkg::QTY_W-1:0] quantity;

    plbook_pkg::cmd_t cmd;
    plbook_pkg::sts_t sts;

    assign req_type    = s_axis_tuser[plbook_pkg::TU_REQ];
    assign book_side   = s_axis_tuser[plbook_pkg::TU_SIDE];
    assign clear_level = s_axis_tuser[plbook_pkg::TU_CLR];
    assign price_level = s_axis_tdata[plbook_pkg::TD_LEVEL_LO +: plbook_pkg::LEVEL_W];
    assign quantity    = s_axis_tdata[plbook_pkg::TD_QTY_LO +: plbook_pkg::QTY_W];

    // sequencer: clearing pass, update write-back, scan and result hand-off
    plbook_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_req   (req_type),
        .sts      (sts),
        .in_ready (s_axis_tready),
        .cmd      (cmd)
    );

    // tables, level counter, sum/multiply/accumulate pipeline, output register
    plbook_dp #(
        .LEVELS (LEVELS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .book_side     (book_side),
        .price_level   (price_level),
        .clear_level   (clear_level),
        .quantity      ($unsigned(quantity)),
        .out_ready     (m_axis_tready),
        .out_valid     (m_axis_tvalid),
        .book_checksum (m_axis_tdata)
    );

`ifndef SYNTHESIS
    // no item is taken while the tables are being cleared
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear_step |-> !s_axis_tready)
        else $error("item taken during table clear");

    // the result register is only loaded when its old item is gone
    a_out_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!m_axis_tvalid || m_axis_tready))
        else $error("result overwritten before it was taken");

    // a scan starts only from an accepted checksum item and blocks input next cycle
    a_scan_start: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_start |-> (s_axis_tvalid && s_axis_tready
                            && req_type == plbook_pkg::REQ_CHECKSUM))
        else $error("scan started without a checksum item");

    a_scan_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_start |=> (cmd.scan_step && !s_axis_tready))
        else $error("scan did not follow its checksum item");
`endif

endmodule

// ===== design/plbook_ram.sv =====
// plbook_ram: generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module plbook_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/plbook_ctrl.sv =====
// plbook_ctrl: sequencer for table clearing, level updates and checksum scans
// depends on plbook_pkg
`timescale 1ns / 1ps

module plbook_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_req,
    input  plbook_pkg::sts_t  sts,
    output logic              in_ready,
    output plbook_pkg::cmd_t  cmd
);

    plbook_pkg::ctrl_state_t state_reg;
    plbook_pkg::ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= plbook_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            plbook_pkg::ST_CLEAR:
            begin
                if (sts.cnt_last)
                begin
                    state_next = plbook_pkg::ST_IDLE;
                end
            end
            plbook_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (in_req == plbook_pkg::REQ_CHECKSUM) ?
                                 plbook_pkg::ST_SUM_RUN : plbook_pkg::ST_UPD_WR;
                end
            end
            plbook_pkg::ST_UPD_WR:
            begin
                state_next = plbook_pkg::ST_IDLE;
            end
            plbook_pkg::ST_SUM_RUN:
            begin
                if (sts.cnt_last)
                begin
                    state_next = plbook_pkg::ST_SUM_DRAIN;
                end
            end
            plbook_pkg::ST_SUM_DRAIN:
            begin
                if (!sts.pipe_busy)
                begin
                    state_next = plbook_pkg::ST_SUM_DONE;
                end
            end
            plbook_pkg::ST_SUM_DONE:
            begin
                if (sts.out_free)
                begin
                    state_next = plbook_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = plbook_pkg::ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            plbook_pkg::ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
            end
            plbook_pkg::ST_IDLE:
            begin
                in_ready       = 1'b1;
                cmd.take_item  = in_valid;
                cmd.scan_start = in_valid && (in_req == plbook_pkg::REQ_CHECKSUM);
            end
            plbook_pkg::ST_UPD_WR:
            begin
                cmd.upd_write = 1'b1;
            end
            plbook_pkg::ST_SUM_RUN:
            begin
                cmd.scan_step = 1'b1;
            end
            plbook_pkg::ST_SUM_DRAIN:
            begin
                cmd = '0;
            end
            plbook_pkg::ST_SUM_DONE:
            begin
                cmd.out_load = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== design/plbook_dp.sv =====
// plbook_dp: bid and ask tables, update read-modify-write, checksum pipeline
// depends on plbook_pkg and plbook_ram
`timescale 1ns / 1ps

module plbook_dp #(
    parameter int LEVELS = 4096
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  plbook_pkg::cmd_t                 cmd,
    output plbook_pkg::sts_t                 sts,
    input  logic                             book_side,
    input  logic [plbook_pkg::LEVEL_W-1:0]   price_level,
    input  logic                             clear_level,
    input  logic [plbook_pkg::QTY_W-1:0]     quantity,
    input  logic                             out_ready,
    output logic                             out_valid,
    output logic [plbook_pkg::CSUM_W-1:0]    book_checksum
);

    localparam int AW = $clog2(LEVELS);
    // wide enough for the item's level and for LEVELS itself
    localparam int CW = (AW + 1 > plbook_pkg::LEVEL_W) ? AW + 1 : plbook_pkg::LEVEL_W;

    localparam int QW = plbook_pkg::QTY_W;
    localparam int SW = plbook_pkg::CSUM_W;

    // level counter for clearing and scanning
    logic [AW-1:0] cnt_reg;
    logic [AW-1:0] cnt_next;
    logic          cnt_last;

    // latched update
    logic          side_reg;
    logic          clr_reg;
    logic [QW-1:0] qty_reg;
    logic [AW-1:0] upd_addr_reg;
    logic          in_range_reg;

    // scan pipeline
    logic          s1_valid_reg;
    logic [AW:0]   s1_weight_reg;
    logic          s2_valid_reg;
    logic [AW:0]   s2_weight_reg;
    logic [QW-1:0] sum_reg;
    logic          s3_valid_reg;
    logic [QW-1:0] prod_reg;
    logic [SW-1:0] acc_reg;

    // output register
    logic          out_valid_reg;
    logic [SW-1:0] out_data_reg;

    logic [CW-1:0] masked_level;
    logic          in_range;
    logic [AW-1:0] in_addr;

    logic [AW-1:0] raddr;
    logic [AW-1:0] waddr;
    logic [QW-1:0] wdata;
    logic [QW-1:0] bid_rdata;
    logic [QW-1:0] ask_rdata;
    logic [QW-1:0] side_rdata;
    logic [QW-1:0] upd_value;
    logic          bid_we;
    logic          ask_we;
    logic          upd_we;

    // level used is price_level masked by LEVELS-1; out of range is dropped
    assign masked_level = CW'(price_level) & CW'(LEVELS - 1);
    assign in_range     = masked_level < CW'(LEVELS);
    assign in_addr      = masked_level[AW-1:0];

    assign cnt_last = (cnt_reg == AW'(LEVELS - 1));

    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.scan_start)
        begin
            cnt_next = '0;
        end
        else if (cmd.clear_step || cmd.scan_step)
        begin
            cnt_next = cnt_last ? '0 : cnt_reg + AW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg      <= cnt_next;
            s1_valid_reg <= cmd.scan_step;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_item)
        begin
            side_reg     <= book_side;
            clr_reg      <= clear_level;
            qty_reg      <= quantity;
            upd_addr_reg <= in_addr;
            in_range_reg <= in_range;
        end
        s1_weight_reg <= (AW + 1)'(cnt_reg) + (AW + 1)'(1);
        s2_weight_reg <= s1_weight_reg;
        sum_reg       <= bid_rdata + ask_rdata;
        prod_reg      <= QW'(sum_reg * s2_weight_reg);
        if (cmd.scan_start)
        begin
            acc_reg <= '0;
        end
        else if (s3_valid_reg)
        begin
            acc_reg <= acc_reg + {{(SW - QW){prod_reg[QW-1]}}, prod_reg};
        end
        if (cmd.out_load)
        begin
            out_data_reg <= acc_reg;
        end
    end

    // table access
    assign raddr      = cmd.take_item ? in_addr : cnt_reg;
    assign side_rdata = (side_reg == plbook_pkg::SIDE_ASK) ? ask_rdata : bid_rdata;
    assign upd_value  = clr_reg ? '0 : side_rdata + qty_reg;
    assign upd_we     = cmd.upd_write && in_range_reg;
    assign waddr      = cmd.clear_step ? cnt_reg : upd_addr_reg;
    assign wdata      = cmd.clear_step ? '0 : upd_value;
    assign bid_we     = cmd.clear_step || (upd_we && (side_reg == plbook_pkg::SIDE_BID));
    assign ask_we     = cmd.clear_step || (upd_we && (side_reg == plbook_pkg::SIDE_ASK));

    plbook_ram #(
        .WIDTH (QW),
        .DEPTH (LEVELS)
    ) u_bid_ram (
        .clk   (clk),
        .we    (bid_we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (bid_rdata)
    );

    plbook_ram #(
        .WIDTH (QW),
        .DEPTH (LEVELS)
    ) u_ask_ram (
        .clk   (clk),
        .we    (ask_we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (ask_rdata)
    );

    assign sts.cnt_last  = cnt_last;
    assign sts.pipe_busy = s1_valid_reg || s2_valid_reg || s3_valid_reg;
    assign sts.out_free  = !out_valid_reg || out_ready;

    assign out_valid     = out_valid_reg;
    assign book_checksum = out_data_reg;

endmodule

// ===== test/price_level_book_with_checksum_test.sv =====
// price_level_book_with_checksum_test: stream testbench for the bid/ask level book
// mirrors both level tables, predicts each weighted checksum and compares it on the output stream
// depends on plbook_pkg and price_level_book_with_checksum
`timescale 1ns / 1ps

module price_level_book_with_checksum_test;

    localparam int BOOK_LEVELS = 4096;
    localparam int RAND_ITEMS  = 1300;
    localparam int CALM_ITEMS  = 150;   // trailing random items sent with no idling
    localparam int HOLD_CYCLES = 3 * BOOK_LEVELS;
    localparam int DRAIN_WAIT  = 20;

    logic                               clk;
    logic                               rst_n;
    logic                               s_axis_tvalid;
    logic                               s_axis_tready;
    // [11:0] price_level, [43:12] quantity, [47:44] zero
    logic [plbook_pkg::IN_TDATA_W-1:0]  s_axis_tdata;
    // [0] req_type, [1] book_side, [2] clear_level
    logic [plbook_pkg::IN_TUSER_W-1:0]  s_axis_tuser;
    logic                               m_axis_tvalid;
    logic                               m_axis_tready;
    // [63:0] book_checksum
    logic [plbook_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

    // shared flags between the item source and the result sink
    logic hold_req;
    logic calm;

    // mirror of both level tables plus the checksums still owed by the block
    class level_book_mirror;
        logic [plbook_pkg::QTY_W-1:0]  bid_qty [BOOK_LEVELS];
        logic [plbook_pkg::QTY_W-1:0]  ask_qty [BOOK_LEVELS];
        logic [plbook_pkg::CSUM_W-1:0] checksums_due [$];
        int                            errors;

        function new();
            foreach (bid_qty[i])
            begin
                bid_qty[i] = '0;
                ask_qty[i] = '0;
            end
            errors = 0;
        endfunction

        // an item taken by the block: apply the update or predict the checksum
        function void take_item(logic [plbook_pkg::IN_TUSER_W-1:0] tuser,
                                logic [plbook_pkg::IN_TDATA_W-1:0] tdata);
            logic [plbook_pkg::LEVEL_W-1:0] level;
            logic [plbook_pkg::QTY_W-1:0]   qty;
            logic [plbook_pkg::QTY_W-1:0]   lvl_sum;
            logic [plbook_pkg::QTY_W-1:0]   weight;
            logic [plbook_pkg::QTY_W-1:0]   prod;
            logic [plbook_pkg::CSUM_W-1:0]  acc;
            int unsigned                    idx;
            level = tdata[plbook_pkg::TD_LEVEL_LO +: plbook_pkg::LEVEL_W];
            qty   = tdata[plbook_pkg::TD_QTY_LO +: plbook_pkg::QTY_W];
            if (tuser[plbook_pkg::TU_REQ] == plbook_pkg::REQ_CHECKSUM)
            begin
                // weighted walk, every step wraps; product sign-extended into 64 bits
                acc = '0;
                for (int i = 0; i < BOOK_LEVELS; i++)
                begin
                    lvl_sum = bid_qty[i] + ask_qty[i];
                    weight  = i + 1;
                    prod    = lvl_sum * weight;
                    acc     = acc + {{(plbook_pkg::CSUM_W - plbook_pkg::QTY_W)
                                      {prod[plbook_pkg::QTY_W-1]}}, prod};
                end
                checksums_due.insert(checksums_due.size(), acc);
                return;
            end
            idx = level & (BOOK_LEVELS - 1);
            // masked index past the table only happens for non power of two sizes
            if (idx >= BOOK_LEVELS)
                return;
            if (tuser[plbook_pkg::TU_SIDE] == plbook_pkg::SIDE_ASK)
                ask_qty[idx] = tuser[plbook_pkg::TU_CLR] ? '0 : ask_qty[idx] + qty;
            else
                bid_qty[idx] = tuser[plbook_pkg::TU_CLR] ? '0 : bid_qty[idx] + qty;
        endfunction

        function void compare_checksum(logic [plbook_pkg::OUT_TDATA_W-1:0] got);
            logic [plbook_pkg::CSUM_W-1:0] want;
            if (checksums_due.size() == 0)
            begin
                $error("book_checksum: no result expected, actual %h", got);
                errors++;
                return;
            end
            want = checksums_due.pop_front();
            if (got !== want)
            begin
                $error("book_checksum: expected %h, actual %h", want, got);
                errors++;
            end
        endfunction

        function int unsigned pending();
            return checksums_due.size();
        endfunction
    endclass

    level_book_mirror book = new();

    price_level_book_with_checksum #(
        .LEVELS(BOOK_LEVELS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watch both streams at the edge; values read here are the ones the block sampled
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                book.take_item(s_axis_tuser, s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                book.compare_checksum(m_axis_tdata);
        end
    end

    // offer one item and hold it until the block takes it
    task automatic send_item(input logic req, input logic side,
                             input logic [plbook_pkg::LEVEL_W-1:0] level,
                             input logic clr, input logic [plbook_pkg::QTY_W-1:0] qty);
        logic [plbook_pkg::IN_TDATA_W-1:0] tdata;
        logic [plbook_pkg::IN_TUSER_W-1:0] tuser;
        tdata = '0;
        tdata[plbook_pkg::TD_LEVEL_LO +: plbook_pkg::LEVEL_W] = level;
        tdata[plbook_pkg::TD_QTY_LO +: plbook_pkg::QTY_W]     = qty;
        tuser = '0;
        tuser[plbook_pkg::TU_REQ]  = req;
        tuser[plbook_pkg::TU_SIDE] = side;
        tuser[plbook_pkg::TU_CLR]  = clr;
        s_axis_tdata  <= tdata;
        s_axis_tuser  <= tuser;
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    task automatic idle_input(input int unsigned cycles);
        s_axis_tvalid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // result sink: random ready and stall bursts, one long hold-off, steady ready at the end
    initial
    begin : result_sink
        int unsigned burst;
        logic        ready_now;
        bit          held;
        held = 1'b0;
        forever
        begin
            if (hold_req === 1'b1 && !held)
            begin
                // long hold so one result waits and the next checksum backs up the input
                held      = 1'b1;
                ready_now = 1'b0;
                burst     = HOLD_CYCLES;
            end
            else if (calm === 1'b1 || $urandom_range(0, 3) != 0)
            begin
                ready_now = 1'b1;
                burst     = $urandom_range(1, 20);
            end
            else
            begin
                ready_now = 1'b0;
                burst     = $urandom_range(1, 14);
            end
            m_axis_tready <= ready_now;
            repeat (burst) @(posedge clk);
        end
    end

    // item source: reset, directed items, then random traffic, then drain and report
    initial
    begin : item_source
        int unsigned                    n;
        logic                           req;
        logic                           side;
        logic                           clr;
        logic [plbook_pkg::LEVEL_W-1:0] level;
        logic [plbook_pkg::QTY_W-1:0]   qty;

        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        hold_req      <= 1'b0;
        calm          <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // checksum of the empty book, other fields all ones and ignored
        send_item(plbook_pkg::REQ_CHECKSUM, plbook_pkg::SIDE_ASK, 12'hfff, 1'b1, 32'hffff_ffff);
        // bid level 0 runs past the positive limit and wraps
        send_item(plbook_pkg::REQ_UPDATE, plbook_pkg::SIDE_BID, 12'd0, 1'b0, 32'h7fff_ffff);
        send_item(plbook_pkg::REQ_UPDATE, plbook_pkg::SIDE_BID, 12'd0, 1'b0, 32'h0000_0001);
        // ask at the same level cancels bid in the 32-bit sum
        send_item(plbook_pkg::REQ_UPDATE, plbook_pkg::SIDE_ASK, 12'd0, 1'b0, 32'h8000_0000);
        // top level: largest weight, product wraps
        send_item(plbook_pkg::REQ_UPDATE, plbook_pkg::SIDE_ASK, 12'hfff, 1'b0, 32'h7fff_ffff);
        send_item(plbook_pkg::REQ_UPDATE, plbook_pkg::SIDE_BID, 12'hfff, 1'b0, 32'hffff_ffff);
        idle_input($urandom_range(1, 14));
        send_item(plbook_pkg::REQ_CHECKSUM, plbook_pkg::SIDE_BID, 12'd0, 1'b0, 32'd0);
        // clear ignores the quantity that comes with it
        send_item(plbook_pkg::REQ_UPDATE, plbook_pkg::SIDE_BID, 12'd0, 1'b1, 32'h1234_5678);
        send_item(plbook_pkg::REQ_UPDATE, plbook_pkg::SIDE_ASK, 12'hfff, 1'b1, 32'h7fff_ffff);
        // most negative quantity added twice wraps back to zero
        send_item(plbook_pkg::REQ_UPDATE, plbook_pkg::SIDE_BID, 12'h800, 1'b0, 32'h8000_0000);
        send_item(plbook_pkg::REQ_UPDATE, plbook_pkg::SIDE_BID, 12'h800, 1'b0, 32'h8000_0000);
        send_item(plbook_pkg::REQ_UPDATE, plbook_pkg::SIDE_ASK, 12'd1, 1'b0, 32'd0);
        send_item(plbook_pkg::REQ_UPDATE, plbook_pkg::SIDE_ASK, 12'd1, 1'b0, 32'hffff_fffb);
        send_item(plbook_pkg::REQ_UPDATE, plbook_pkg::SIDE_ASK, 12'h555, 1'b0, 32'h8000_0000);
        send_item(plbook_pkg::REQ_UPDATE, plbook_pkg::SIDE_BID, 12'haaa, 1'b0, 32'h7fff_ffff);
        send_item(plbook_pkg::REQ_UPDATE, plbook_pkg::SIDE_BID, 12'hfff, 1'b1, 32'd0);
        send_item(plbook_pkg::REQ_CHECKSUM, plbook_pkg::SIDE_ASK, 12'h555, 1'b1, 32'h5555_5555);

        // back-pressure: sink holds off while three checksums queue up behind it
        hold_req <= 1'b1;
        send_item(plbook_pkg::REQ_CHECKSUM, plbook_pkg::SIDE_BID, 12'h123, 1'b0, 32'hdead_beef);
        send_item(plbook_pkg::REQ_UPDATE, plbook_pkg::SIDE_ASK, 12'h3ff, 1'b0, 32'hffff_8000);
        send_item(plbook_pkg::REQ_CHECKSUM, plbook_pkg::SIDE_ASK, 12'h000, 1'b1, 32'h0000_0000);
        send_item(plbook_pkg::REQ_UPDATE, plbook_pkg::SIDE_BID, 12'h3ff, 1'b0, 32'h0000_8000);
        send_item(plbook_pkg::REQ_CHECKSUM, plbook_pkg::SIDE_BID, 12'hfff, 1'b1, 32'hffff_ffff);

        // random traffic: mostly updates hitting hot levels so sums build up, some checksums
        n = 0;
        while (n < RAND_ITEMS)
        begin
            if (n + CALM_ITEMS >= RAND_ITEMS)
                calm <= 1'b1;
            req  = ($urandom_range(0, 99) < 3) ? plbook_pkg::REQ_CHECKSUM
                                               : plbook_pkg::REQ_UPDATE;
            side = 1'($urandom_range(0, 1));
            clr  = ($urandom_range(0, 9) == 0);
            case ($urandom_range(0, 3))
                0:       level = 12'($urandom_range(0, 7));
                1:       level = 12'(4095 - $urandom_range(0, 7));
                default: level = 12'($urandom_range(0, 4095));
            endcase
            case ($urandom_range(0, 9))
                0:       qty = 32'h7fff_ffff;
                1:       qty = 32'h8000_0000;
                2:       qty = 32'hffff_ffff;
                3, 4, 5: qty = 32'($urandom_range(0, 2000)) - 32'd1000;
                default: qty = $urandom();
            endcase
            send_item(req, side, level, clr, qty);
            n++;
            // sender gaps only before the calm tail
            if (n + CALM_ITEMS < RAND_ITEMS && $urandom_range(0, 3) == 0)
                idle_input($urandom_range(1, 14));
        end
        s_axis_tvalid <= 1'b0;

        // drain: every predicted checksum must arrive, then a short quiet window
        do
            @(posedge clk);
        while (book.pending() != 0);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (book.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // watchdog: worst case is every item a checksum (a full level scan each, with
    // stalls) plus the reset sweep and the long hold; this is several times that
    initial
    begin : watchdog
        #300_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
